// ===== rtl/core/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS  = 28;
  localparam int NUM_OWNERS  = 16;
  localparam int MAX_LIVE    = 16;

  localparam int BLOCK_SHIFT = 10;
  localparam int BLOCK_BYTES = 1024;
  localparam int MAX_BYTES   = NUM_BLOCKS * BLOCK_BYTES;

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int LEN_W  = CNT_W;
  localparam int OWN_W  = 4;
  localparam int LIVE_W = $clog2(MAX_LIVE + 1);
  localparam int WIDE_W = 2 * NUM_BLOCKS;

  localparam logic [31:0] HEAP_BASE_RST = 32'h2000_1000;
  localparam logic [4:0]  USABLE_RST    = 5'd28;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_USABLE    = 2'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE_ADDR  = 2'd1,
    CMD_FREE_OWNER = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_FREE_CHK,
    S_OWNER,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] size_bytes;
    logic [31:0] address;
    logic [3:0]  owner;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [27:0] changed_blocks;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [4:0]  usable_blocks;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [OWN_W-1:0] owner;
  } run_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    run_t             wr_data;
  } ram_req_t;

  function automatic logic [NUM_BLOCKS-1:0] run_mask(input logic [IDX_W-1:0] start,
                                                     input logic [LEN_W-1:0] len);
    logic [WIDE_W-1:0] ones;
    logic [WIDE_W-1:0] shifted;
    ones    = (WIDE_W'(1) << len) - WIDE_W'(1);
    shifted = ones << start;
    return shifted[NUM_BLOCKS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bba_run_ram.sv =====
`default_nettype none

module bba_run_ram (
  input  wire               clk,
  input  wire               rst,
  input  bba_pkg::ram_req_t ram,
  output bba_pkg::run_t     rd_data
);
  import bba_pkg::*;

  run_t                  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid;
  run_t                  rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk) begin
    if (ram.wr_en) begin
      mem[ram.wr_addr] <= ram.wr_data;
    end
    if (ram.rd_en) begin
      rd_q <= mem[ram.rd_addr];
    end
  end

  // Entries never written since reset read as an empty run.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ram.wr_en) begin
        valid[ram.wr_addr] <= 1'b1;
      end
      if (ram.rd_en) begin
        rd_valid_q <= valid[ram.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bba_engine.sv =====
`default_nettype none

module bba_engine (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  bba_pkg::req_item_t req,
  input  bba_pkg::cfg_t      cfg,
  input  wire                slot_free,
  output logic               done,
  output bba_pkg::rsp_item_t res,
  output bba_pkg::ram_req_t  ram,
  input  bba_pkg::run_t      rd_data
);
  import bba_pkg::*;

  state_t                state;
  state_t                state_next;
  req_item_t             item;
  logic [NUM_BLOCKS-1:0] free_map;
  logic [LIVE_W-1:0]     live_count;
  logic [LEN_W-1:0]      need;
  logic [CNT_W-1:0]      limit;
  logic [CNT_W-1:0]      cand;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      blk_idx;

  logic                  table_full;
  logic                  bad_size;
  logic [32:0]           size_round;
  logic [31:0]           offset;
  logic [21:0]           blk;
  logic                  addr_ok;
  logic [CNT_W:0]        cand_end;
  logic                  cand_fits;
  logic [NUM_BLOCKS-1:0] cand_mask;
  logic                  alloc_take;
  logic [CNT_W-1:0]      cnt_prev;
  logic [IDX_W-1:0]      rel_idx;
  logic                  rel_hit;
  logic [NUM_BLOCKS-1:0] rel_mask;
  logic                  accept;

  assign accept     = req_valid && req_ready;
  assign table_full = live_count >= LIVE_W'(MAX_LIVE);
  assign bad_size   = (32'(item.owner) >= NUM_OWNERS) || (item.size_bytes == '0) ||
                      (item.size_bytes > 32'(MAX_BYTES));
  assign size_round = {1'b0, item.size_bytes} + 33'(BLOCK_BYTES - 1);
  assign offset     = item.address - cfg.heap_base;
  assign blk        = offset[31:BLOCK_SHIFT];
  assign addr_ok    = (offset[BLOCK_SHIFT-1:0] == '0) && (32'(blk) < NUM_BLOCKS);

  assign cand_end   = (CNT_W + 1)'(cand) + (CNT_W + 1)'(need);
  assign cand_fits  = cand_end <= (CNT_W + 1)'(limit);
  assign cand_mask  = run_mask(cand[IDX_W-1:0], need);
  assign alloc_take = (state == S_ALLOC) && cand_fits && ((free_map & cand_mask) == cand_mask);

  assign cnt_prev = cnt - CNT_W'(1);
  assign rel_idx  = (state == S_OWNER) ? cnt_prev[IDX_W-1:0] : blk_idx;
  assign rel_mask = run_mask(rel_idx, rd_data.length);
  assign rel_hit  = ((state == S_FREE_CHK) && (rd_data.length != '0)) ||
                    ((state == S_OWNER) && (cnt != '0) && (rd_data.length != '0) &&
                     (rd_data.owner == item.owner));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (item.command)
          CMD_ALLOC:      state_next = (table_full || bad_size) ? S_DONE : S_ALLOC;
          CMD_FREE_ADDR:  state_next = addr_ok ? S_FREE_CHK : S_DONE;
          CMD_FREE_OWNER: state_next = S_OWNER;
          default:        state_next = S_DONE;
        endcase
      end
      S_ALLOC: begin
        if (!cand_fits || alloc_take) begin
          state_next = S_DONE;
        end
      end
      S_FREE_CHK: state_next = S_DONE;
      S_OWNER: begin
        if (cnt == CNT_W'(NUM_BLOCKS)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state == S_IDLE);
    done        = (state == S_DONE) && slot_free;
    ram.rd_en   = 1'b0;
    ram.rd_addr = '0;
    if ((state == S_DECODE) && (item.command == CMD_FREE_ADDR) && addr_ok) begin
      ram.rd_en   = 1'b1;
      ram.rd_addr = blk[IDX_W-1:0];
    end else if ((state == S_OWNER) && (cnt < CNT_W'(NUM_BLOCKS))) begin
      ram.rd_en   = 1'b1;
      ram.rd_addr = cnt[IDX_W-1:0];
    end
    ram.wr_en   = alloc_take || rel_hit;
    ram.wr_addr = alloc_take ? cand[IDX_W-1:0] : rel_idx;
    ram.wr_data = alloc_take ? run_t'{length: need, owner: item.owner} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map   <= '1;
      live_count <= '0;
    end else if (alloc_take) begin
      free_map   <= free_map & ~cand_mask;
      live_count <= live_count + LIVE_W'(1);
    end else if (rel_hit) begin
      free_map <= free_map | rel_mask;
      if (live_count != '0) begin
        live_count <= live_count - LIVE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    case (state)
      S_DECODE: begin
        res.status         <= ST_NOT_FOUND;
        res.block_address  <= '0;
        res.changed_blocks <= '0;
        need    <= LEN_W'(size_round >> BLOCK_SHIFT);
        limit   <= (int'(cfg.usable_blocks) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(cfg.usable_blocks);
        cand    <= '0;
        cnt     <= '0;
        blk_idx <= blk[IDX_W-1:0];
        if (item.command == CMD_ALLOC) begin
          if (table_full) begin
            res.status <= ST_TABLE_FULL;
          end else if (bad_size) begin
            res.status <= ST_BAD_SIZE;
          end
        end else if (item.command == CMD_FREE_OWNER) begin
          res.status <= ST_OK;
        end
      end
      S_ALLOC: begin
        if (!cand_fits) begin
          res.status <= ST_NO_SPACE;
        end else if (alloc_take) begin
          res.status         <= ST_OK;
          res.block_address  <= cfg.heap_base + (32'(cand) << BLOCK_SHIFT);
          res.changed_blocks <= 28'(cand_mask);
        end else begin
          cand <= cand + CNT_W'(1);
        end
      end
      S_FREE_CHK: begin
        if (rel_hit) begin
          res.status         <= ST_OK;
          res.block_address  <= item.address;
          res.changed_blocks <= 28'(rel_mask);
        end
      end
      S_OWNER: begin
        cnt <= cnt + CNT_W'(1);
        if (rel_hit) begin
          res.changed_blocks <= res.changed_blocks | 28'(rel_mask);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_block_allocator.sv =====
`default_nettype none

// Channel | Signals                               | Role
// req     | req_valid, req_ready, req             | command item in
// rsp     | rsp_valid, rsp_ready, rsp             | result item out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Allocate decodes the item, then tries one candidate start block per cycle
// from block 0 up until a free run fits or none fits. Free by address reads
// the named block's run, or ends after decode when the address names no
// block; free all of owner does one registered run-table read per cycle.
// Reset frees every block; the run table needs no clearing pass.
// A new item is taken while a result still waits in the output register;
// the engine stalls in its last state only when that register is still full.

module bitmap_block_allocator (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  bba_pkg::req_item_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output bba_pkg::rsp_item_t rsp,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [31:0]         cfg_data
);
  import bba_pkg::*;

  cfg_t      cfg;
  logic      slot_free;
  logic      done;
  rsp_item_t res;
  ram_req_t  ram;
  run_t      rd_data;

  assign cfg_ready = 1'b1;
  assign slot_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base     <= HEAP_BASE_RST;
      cfg.usable_blocks <= USABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAP_BASE: cfg.heap_base     <= cfg_data;
        CFG_USABLE:    cfg.usable_blocks <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= res;
    end
  end

  bba_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg       (cfg),
    .slot_free (slot_free),
    .done      (done),
    .res       (res),
    .ram       (ram),
    .rd_data   (rd_data)
  );

  bba_run_ram u_run_ram (
    .clk     (clk),
    .rst     (rst),
    .ram     (ram),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
